[rtl/sng_pkg.sv]
// Shared types and constants for the square/noise sound generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package sng_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned ATT_W    = 4;
    localparam int unsigned AMP_W    = 13;
    localparam int unsigned SAMPLE_W = 14;
    localparam int unsigned SUM_W    = 17;

    localparam logic [15:0] LFSR_SEED = 16'h8000;

    localparam logic [PERIOD_W-1:0] NOISE_PERIOD_16 = 10'h010;
    localparam logic [PERIOD_W-1:0] NOISE_PERIOD_32 = 10'h020;
    localparam logic [PERIOD_W-1:0] NOISE_PERIOD_64 = 10'h040;

    localparam logic [1:0] NOISE_RATE_16   = 2'd0;
    localparam logic [1:0] NOISE_RATE_32   = 2'd1;
    localparam logic [1:0] NOISE_RATE_64   = 2'd2;

    localparam logic [1:0] NOISE_CHANNEL = 2'd3;

    // Polarity and attenuation of all four channels after one tick.
    typedef struct packed {
        logic [3:0]            phase;
        logic [3:0][ATT_W-1:0] att;
    } t_mix;

    // Amplitude for each attenuation step; step 15 is silence.
    function automatic logic [AMP_W-1:0] amp_of_att(input logic [ATT_W-1:0] a);
        logic [AMP_W-1:0] amp;
        case (a)
            4'd0:    amp = 13'd8191;
            4'd1:    amp = 13'd6507;
            4'd2:    amp = 13'd5168;
            4'd3:    amp = 13'd4105;
            4'd4:    amp = 13'd3261;
            4'd5:    amp = 13'd2590;
            4'd6:    amp = 13'd2057;
            4'd7:    amp = 13'd1634;
            4'd8:    amp = 13'd1298;
            4'd9:    amp = 13'd1031;
            4'd10:   amp = 13'd819;
            4'd11:   amp = 13'd650;
            4'd12:   amp = 13'd516;
            4'd13:   amp = 13'd410;
            4'd14:   amp = 13'd326;
            default: amp = 13'd0;
        endcase
        return amp;
    endfunction

endpackage

`default_nettype wire

[rtl/sng_if.sv]
// Valid/ready channel interfaces for the sound generator's input and output.
// Depends on sng_pkg for field widths.
`default_nettype none

interface sng_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] write_byte;

    modport source (output valid, output opcode, output write_byte, input ready);
    modport sink   (input valid, input opcode, input write_byte, output ready);
endinterface

interface sng_out_if
    import sng_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/sng_core.sv]
// Generator state: register write decode, tone and noise counters, noise LFSR.
// Depends on sng_pkg; feeds the post-tick channel state to sng_mixer.
`default_nettype none

module sng_core
    import sng_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_byte,
    output t_mix            o_mix
);

    logic [PERIOD_W-1:0] r_tone_period [3];
    logic [PERIOD_W-1:0] r_tone_count  [3];
    logic [2:0]          r_tone_phase;
    logic [2:0]          r_noise_mode;
    logic [15:0]         r_noise_lfsr;
    logic [PERIOD_W-1:0] r_noise_count;
    logic                r_noise_phase;
    logic [ATT_W-1:0]    r_att [4];
    logic [1:0]          r_latch_ch;
    logic                r_latch_vol;

    logic [PERIOD_W-1:0] n_tone_count [3];
    logic [2:0]          n_tone_phase;
    logic [PERIOD_W-1:0] n_noise_count;
    logic                n_noise_phase;
    logic [15:0]         n_noise_lfsr;
    logic [PERIOD_W-1:0] noise_period;
    logic                noise_reload;
    logic                noise_fb;
    logic [1:0]          eff_ch;
    logic                eff_vol;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_tone_count[i] <= PERIOD_W'(1)) begin
                n_tone_count[i] = (r_tone_period[i] == '0) ? PERIOD_W'(1) : r_tone_period[i];
                n_tone_phase[i] = ~r_tone_phase[i];
            end else begin
                n_tone_count[i] = r_tone_count[i] - PERIOD_W'(1);
                n_tone_phase[i] = r_tone_phase[i];
            end
        end

        case (r_noise_mode[1:0])
            NOISE_RATE_16: noise_period = NOISE_PERIOD_16;
            NOISE_RATE_32: noise_period = NOISE_PERIOD_32;
            NOISE_RATE_64: noise_period = NOISE_PERIOD_64;
            default:       noise_period = (r_tone_period[2] == '0) ? PERIOD_W'(1)
                                                                     : r_tone_period[2];
        endcase

        noise_reload  = (r_noise_count <= PERIOD_W'(1));
        n_noise_count = noise_reload ? noise_period : r_noise_count - PERIOD_W'(1);
        n_noise_phase = r_noise_phase ^ noise_reload;
        noise_fb      = r_noise_lfsr[0] ^ (r_noise_mode[2] & r_noise_lfsr[3]);
        // The register shifts only on the toggle that returns the phase to positive.
        n_noise_lfsr  = (noise_reload && n_noise_phase) ? {noise_fb, r_noise_lfsr[15:1]}
                                                        : r_noise_lfsr;

        eff_ch  = i_byte[7] ? i_byte[6:5] : r_latch_ch;
        eff_vol = i_byte[7] ? i_byte[4]   : r_latch_vol;

        o_mix.phase = {n_noise_lfsr[0], n_tone_phase};
        for (int k = 0; k < 4; k++) begin
            o_mix.att[k] = r_att[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_tone_period[i] <= '0;
                r_tone_count[i]  <= '0;
            end
            r_tone_phase  <= '1;
            r_noise_mode  <= '0;
            r_noise_lfsr  <= LFSR_SEED;
            r_noise_count <= '0;
            r_noise_phase <= 1'b1;
            for (int k = 0; k < 4; k++) begin
                r_att[k] <= '1;
            end
            r_latch_ch  <= '0;
            r_latch_vol <= 1'b0;
        end else if (i_step) begin
            if (i_opcode == OP_TICK) begin
                for (int i = 0; i < 3; i++) begin
                    r_tone_count[i] <= n_tone_count[i];
                end
                r_tone_phase  <= n_tone_phase;
                r_noise_count <= n_noise_count;
                r_noise_phase <= n_noise_phase;
                r_noise_lfsr  <= n_noise_lfsr;
            end else begin
                if (i_byte[7]) begin
                    r_latch_ch  <= i_byte[6:5];
                    r_latch_vol <= i_byte[4];
                end
                if (eff_vol) begin
                    r_att[eff_ch] <= i_byte[ATT_W-1:0];
                end else if (eff_ch == NOISE_CHANNEL) begin
                    r_noise_mode <= i_byte[2:0];
                    r_noise_lfsr <= LFSR_SEED;
                end else if (i_byte[7]) begin
                    r_tone_period[eff_ch] <= {r_tone_period[eff_ch][9:4], i_byte[3:0]};
                end else begin
                    r_tone_period[eff_ch] <= {i_byte[5:0], r_tone_period[eff_ch][3:0]};
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/sng_mixer.sv]
// Mixer: signed, table-weighted sum of the four channels, floored by four.
// Depends on sng_pkg for the amplitude table and the t_mix struct.
`default_nettype none

module sng_mixer
    import sng_pkg::*;
(
    input  t_mix                       i_mix,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    logic signed [SUM_W-1:0] term [4];
    logic signed [SUM_W-1:0] sum;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            term[k] = SUM_W'(amp_of_att(i_mix.att[k]));
            if (!i_mix.phase[k]) begin
                term[k] = -term[k];
            end
        end
        sum = (term[0] + term[1]) + (term[2] + term[3]);
        // Dropping the two low bits of a two's complement value floors toward minus infinity.
        o_sample = sum[SAMPLE_W+1:2];
    end

endmodule

`default_nettype wire

[rtl/square_noise_sound_generator.sv]
// Four-channel square/noise sound generator.
// A tick transfer's sample passes through the input register and then the result register.
// Throughput: one item per cycle unless a tick meets a waiting sample that is not taken; write bytes go on.
// Reset (synchronous, active low): all periods and counters zero, phases positive,
// every channel silent, noise shift register 0x8000, no item or sample pending.
`default_nettype none

module square_noise_sound_generator
    import sng_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sng_in_if.sink    i_in,
    sng_out_if.source o_out
);

    logic                       r_in_valid;
    logic                       r_in_op;
    logic [7:0]                 r_in_byte;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic                       advance;
    t_mix                       mix;
    logic signed [SAMPLE_W-1:0] mix_sample;

    // A write byte never needs the result register, so it moves on even when a sample waits.
    assign advance = r_in_valid && ((r_in_op == OP_WRITE) || !r_out_valid || o_out.ready);

    assign i_in.ready   = !r_in_valid || advance;
    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;

    sng_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_opcode (r_in_op),
        .i_byte   (r_in_byte),
        .o_mix    (mix)
    );

    sng_mixer u_mixer (
        .i_mix    (mix),
        .o_sample (mix_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && (r_in_op == OP_TICK)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= i_in.opcode;
            r_in_byte <= i_in.write_byte;
        end
        if (advance && (r_in_op == OP_TICK)) begin
            r_sample <= mix_sample;
        end
    end

endmodule

`default_nettype wire
